@@ rtl/tpo_pkg.sv @@
// Shared types, constants and decision functions for the triangle pair overlap test.
package tpo_pkg;

   // Field and datapath widths.
   localparam int CoordW    = 15;
   localparam int DiffW     = CoordW + 1;
   localparam int ProdW     = 2 * DiffW;
   localparam int DetW      = ProdW + 1;
   localparam int OrientLat = 3;
   localparam int SubW      = 3;
   localparam int CodeW     = 19;
   localparam int NumCoords = 12;
   localparam int ReqDataW  = 184;
   localparam int RspDataW  = 32;

   // Sub-test result codes that the decision tree refers to by name.
   localparam logic [SubW-1:0] SUB_NONE   = 3'd0;
   localparam logic [SubW-1:0] SUB_INSIDE = 3'd1;
   localparam logic [SubW-1:0] SUB_1      = 3'd1;
   localparam logic [SubW-1:0] SUB_2      = 3'd2;
   localparam logic [SubW-1:0] SUB_3      = 3'd3;
   localparam logic [SubW-1:0] SUB_4      = 3'd4;
   localparam logic [SubW-1:0] SUB_5      = 3'd5;

   // Region of the first triangle's p vertex against the second triangle.
   typedef enum logic [2:0] {
      BR_INSIDE   = 3'd0,
      BR_EDGE_PQR = 3'd1,
      BR_EDGE_RPQ = 3'd2,
      BR_VERT_PQR = 3'd3,
      BR_VERT_RPQ = 3'd4,
      BR_EDGE_QRP = 3'd5,
      BR_VERT_QRP = 3'd6
   } branch_type;

   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
   } point_type;

   typedef struct packed {
      point_type p;
      point_type q;
      point_type r;
   } triangle_type;

   // Sign of one orientation determinant.
   typedef struct packed {
      logic neg;
      logic zero;
   } orient_flags_type;

   // First triangle plus the second triangle rotated for the chosen sub-test.
   typedef struct packed {
      branch_type   branch;
      triangle_type a;
      triangle_type rot;
   } region_type;

   // Orientation signs used by the edge and vertex sub-tests.
   // Naming: A vertices p1, q1, r1; rotated B vertices P, Q, R.
   typedef struct packed {
      orient_flags_type rp_q1;   // (R, P, q1)
      orient_flags_type rq_q1;   // (R, Q, q1)
      orient_flags_type p1_p_q1; // (p1, P, q1)
      orient_flags_type p1_q_q1; // (p1, Q, q1)
      orient_flags_type p1_p_r1; // (p1, P, r1)
      orient_flags_type q1r1_p;  // (q1, r1, P)
      orient_flags_type rq_r1;   // (R, Q, r1)
      orient_flags_type q1r1_q;  // (q1, r1, Q)
      orient_flags_type rp_r1;   // (R, P, r1)
      orient_flags_type q1r1_r;  // (q1, r1, R)
      orient_flags_type r_r1_q;  // (R, r1, Q)
      orient_flags_type p1q1_r;  // (p1, q1, R)
      orient_flags_type r1p1_p;  // (r1, p1, P)
      orient_flags_type p1r1_r;  // (p1, r1, R)
   } sub_flags_type;

   typedef struct packed {
      logic             overlap;
      branch_type       branch;
      logic [SubW-1:0]  subcase;
      logic [CodeW-1:0] code;
   } result_type;

   function automatic logic is_ge0(orient_flags_type f);
      return !f.neg;
   endfunction

   function automatic logic is_le0(orient_flags_type f);
      return f.neg || f.zero;
   endfunction

   function automatic logic is_gt0(orient_flags_type f);
      return !f.neg && !f.zero;
   endfunction

   function automatic logic is_lt0(orient_flags_type f);
      return f.neg;
   endfunction

   // Vertex sub-test: p1 lies in a vertex region of the rotated triangle.
   function automatic logic [SubW-1:0] vertex_sub(sub_flags_type f);
      logic [SubW-1:0] sc;
      sc = SUB_NONE;
      if (is_ge0(f.rp_q1)) begin
         if (is_le0(f.rq_q1)) begin
            if (is_gt0(f.p1_p_q1)) begin
               sc = is_le0(f.p1_q_q1) ? SUB_1 : SUB_NONE;
            end else if (is_lt0(f.p1_p_r1)) begin
               sc = SUB_NONE;
            end else begin
               sc = is_ge0(f.q1r1_p) ? SUB_2 : SUB_NONE;
            end
         end else if (is_gt0(f.p1_q_q1) || is_gt0(f.rq_r1)) begin
            sc = SUB_NONE;
         end else begin
            sc = is_ge0(f.q1r1_q) ? SUB_3 : SUB_NONE;
         end
      end else if (is_lt0(f.rp_r1)) begin
         sc = SUB_NONE;
      end else if (is_ge0(f.q1r1_r)) begin
         sc = is_ge0(f.p1_p_r1) ? SUB_4 : SUB_NONE;
      end else if (is_lt0(f.q1r1_q)) begin
         sc = SUB_NONE;
      end else begin
         sc = is_ge0(f.r_r1_q) ? SUB_5 : SUB_NONE;
      end
      return sc;
   endfunction

   // Edge sub-test: p1 lies in an edge region of the rotated triangle.
   function automatic logic [SubW-1:0] edge_sub(sub_flags_type f);
      logic [SubW-1:0] sc;
      sc = SUB_NONE;
      if (is_ge0(f.rp_q1)) begin
         if (is_ge0(f.p1_p_q1)) begin
            sc = is_ge0(f.p1q1_r) ? SUB_1 : SUB_NONE;
         end else if (is_lt0(f.q1r1_p)) begin
            sc = SUB_NONE;
         end else begin
            sc = is_ge0(f.r1p1_p) ? SUB_2 : SUB_NONE;
         end
      end else if (is_lt0(f.rp_r1) || is_lt0(f.p1_p_r1)) begin
         sc = SUB_NONE;
      end else if (is_ge0(f.p1r1_r)) begin
         sc = SUB_3;
      end else begin
         sc = is_ge0(f.q1r1_r) ? SUB_4 : SUB_NONE;
      end
      return sc;
   endfunction

   // Sub-case shifted by the region's position in the packed code.
   function automatic logic [CodeW-1:0] pack_code(branch_type br, logic [SubW-1:0] sc);
      logic [CodeW-1:0] wide;
      logic [CodeW-1:0] res;
      wide = {{(CodeW - SubW){1'b0}}, sc};
      unique case (br)
         BR_INSIDE:   res = wide;
         BR_EDGE_PQR: res = wide << 1;
         BR_EDGE_RPQ: res = wide << 4;
         BR_VERT_PQR: res = wide << 7;
         BR_VERT_RPQ: res = wide << 10;
         BR_EDGE_QRP: res = wide << 13;
         BR_VERT_QRP: res = wide << 16;
         default:     res = '0;
      endcase
      return res;
   endfunction

endpackage

@@ rtl/tpo_orient.sv @@
// Three-stage orientation determinant of points a, b, c, reduced to its sign.
module tpo_orient (
   input  logic                      clock,
   input  logic                      en,
   input  tpo_pkg::point_type        a,
   input  tpo_pkg::point_type        b,
   input  tpo_pkg::point_type        c,
   output tpo_pkg::orient_flags_type flags
);
   import tpo_pkg::*;

   logic signed [DiffW-1:0] dax_in, dby_in, day_in, dbx_in;
   logic signed [DiffW-1:0] dax_ff, dby_ff, day_ff, dbx_ff;
   logic signed [ProdW-1:0] prod1_in, prod2_in, prod1_ff, prod2_ff;
   logic signed [DetW-1:0]  det;
   orient_flags_type        flags_in, flags_ff;

   // Stage one: coordinate differences relative to c.
   always_comb begin
      dax_in = $signed({a.x[CoordW-1], a.x}) - $signed({c.x[CoordW-1], c.x});
      dby_in = $signed({b.y[CoordW-1], b.y}) - $signed({c.y[CoordW-1], c.y});
      day_in = $signed({a.y[CoordW-1], a.y}) - $signed({c.y[CoordW-1], c.y});
      dbx_in = $signed({b.x[CoordW-1], b.x}) - $signed({c.x[CoordW-1], c.x});
   end

   // Stage two: the two cross products.
   always_comb begin
      prod1_in = dax_ff * dby_ff;
      prod2_in = day_ff * dbx_ff;
   end

   // Stage three: the difference of the products, kept as sign and zero flags.
   always_comb begin
      det = $signed({prod1_ff[ProdW-1], prod1_ff}) - $signed({prod2_ff[ProdW-1], prod2_ff});
      flags_in.neg  = det[DetW-1];
      flags_in.zero = (det == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dax_ff   <= dax_in;
         dby_ff   <= dby_in;
         day_ff   <= day_in;
         dbx_ff   <= dbx_in;
         prod1_ff <= prod1_in;
         prod2_ff <= prod2_in;
         flags_ff <= flags_in;
      end
   end

   assign flags = flags_ff;

endmodule

@@ rtl/tpo_region.sv @@
// Classifies vertex p of the first triangle against the second and rotates the second.
module tpo_region (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  tpo_pkg::triangle_type a_trg,
   input  tpo_pkg::triangle_type b_trg,
   output logic                  out_valid,
   output tpo_pkg::region_type   region
);
   import tpo_pkg::*;

   orient_flags_type f_pq, f_qr, f_rp;
   logic             valid_dly_ff [OrientLat];
   triangle_type     a_dly_ff     [OrientLat];
   triangle_type     b_dly_ff     [OrientLat];
   triangle_type     a_at, b_at;
   region_type       region_in, region_ff;
   logic             valid_ff;

   // Edge-line orientations of p1 against edges pq, qr and rp of the second triangle.
   tpo_orient u_orient_pq (.clock(clock), .en(en), .a(b_trg.p), .b(b_trg.q), .c(a_trg.p),
                           .flags(f_pq));
   tpo_orient u_orient_qr (.clock(clock), .en(en), .a(b_trg.q), .b(b_trg.r), .c(a_trg.p),
                           .flags(f_qr));
   tpo_orient u_orient_rp (.clock(clock), .en(en), .a(b_trg.r), .b(b_trg.p), .c(a_trg.p),
                           .flags(f_rp));

   // Valid bits travel beside the determinant pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OrientLat; i++) begin
            valid_dly_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_dly_ff[0] <= in_valid;
         for (int i = 1; i < OrientLat; i++) begin
            valid_dly_ff[i] <= valid_dly_ff[i-1];
         end
      end
   end

   // Vertex data travels beside the determinant pipeline.
   always_ff @(posedge clock) begin
      if (en) begin
         a_dly_ff[0] <= a_trg;
         b_dly_ff[0] <= b_trg;
         for (int i = 1; i < OrientLat; i++) begin
            a_dly_ff[i] <= a_dly_ff[i-1];
            b_dly_ff[i] <= b_dly_ff[i-1];
         end
      end
   end

   assign a_at = a_dly_ff[OrientLat-1];
   assign b_at = b_dly_ff[OrientLat-1];

   // Region decision and the matching rotation of the second triangle.
   always_comb begin
      region_in.a = a_at;
      if (is_ge0(f_pq)) begin
         if (is_ge0(f_qr)) begin
            region_in.branch = is_ge0(f_rp) ? BR_INSIDE : BR_EDGE_PQR;
         end else begin
            region_in.branch = is_ge0(f_rp) ? BR_EDGE_RPQ : BR_VERT_PQR;
         end
      end else if (is_lt0(f_qr)) begin
         region_in.branch = BR_VERT_RPQ;
      end else begin
         region_in.branch = is_ge0(f_rp) ? BR_EDGE_QRP : BR_VERT_QRP;
      end

      case (region_in.branch) inside
         BR_EDGE_RPQ, BR_VERT_RPQ: begin
            region_in.rot.p = b_at.r;
            region_in.rot.q = b_at.p;
            region_in.rot.r = b_at.q;
         end
         BR_EDGE_QRP, BR_VERT_QRP: begin
            region_in.rot.p = b_at.q;
            region_in.rot.q = b_at.r;
            region_in.rot.r = b_at.p;
         end
         default: begin
            region_in.rot = b_at;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_dly_ff[OrientLat-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         region_ff <= region_in;
      end
   end

   assign out_valid = valid_ff;
   assign region    = region_ff;

endmodule

@@ rtl/tpo_subtest.sv @@
// Edge and vertex sub-tests on the rotated second triangle, and the result fields.
module tpo_subtest (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  tpo_pkg::region_type    region,
   output logic                   out_valid,
   output tpo_pkg::result_type    result
);
   import tpo_pkg::*;

   sub_flags_type   f;
   logic            valid_dly_ff  [OrientLat];
   branch_type      branch_dly_ff [OrientLat];
   branch_type      br;
   logic [SubW-1:0] sc;
   point_type       p1, q1, r1, bp, bq, br_pt;

   assign p1    = region.a.p;
   assign q1    = region.a.q;
   assign r1    = region.a.r;
   assign bp    = region.rot.p;
   assign bq    = region.rot.q;
   assign br_pt = region.rot.r;

   // All orientations either sub-test may consult, computed side by side.
   tpo_orient u_rp_q1   (.clock(clock), .en(en), .a(br_pt), .b(bp), .c(q1), .flags(f.rp_q1));
   tpo_orient u_rq_q1   (.clock(clock), .en(en), .a(br_pt), .b(bq), .c(q1), .flags(f.rq_q1));
   tpo_orient u_p1_p_q1 (.clock(clock), .en(en), .a(p1), .b(bp), .c(q1), .flags(f.p1_p_q1));
   tpo_orient u_p1_q_q1 (.clock(clock), .en(en), .a(p1), .b(bq), .c(q1), .flags(f.p1_q_q1));
   tpo_orient u_p1_p_r1 (.clock(clock), .en(en), .a(p1), .b(bp), .c(r1), .flags(f.p1_p_r1));
   tpo_orient u_q1r1_p  (.clock(clock), .en(en), .a(q1), .b(r1), .c(bp), .flags(f.q1r1_p));
   tpo_orient u_rq_r1   (.clock(clock), .en(en), .a(br_pt), .b(bq), .c(r1), .flags(f.rq_r1));
   tpo_orient u_q1r1_q  (.clock(clock), .en(en), .a(q1), .b(r1), .c(bq), .flags(f.q1r1_q));
   tpo_orient u_rp_r1   (.clock(clock), .en(en), .a(br_pt), .b(bp), .c(r1), .flags(f.rp_r1));
   tpo_orient u_q1r1_r  (.clock(clock), .en(en), .a(q1), .b(r1), .c(br_pt), .flags(f.q1r1_r));
   tpo_orient u_r_r1_q  (.clock(clock), .en(en), .a(br_pt), .b(r1), .c(bq), .flags(f.r_r1_q));
   tpo_orient u_p1q1_r  (.clock(clock), .en(en), .a(p1), .b(q1), .c(br_pt), .flags(f.p1q1_r));
   tpo_orient u_r1p1_p  (.clock(clock), .en(en), .a(r1), .b(p1), .c(bp), .flags(f.r1p1_p));
   tpo_orient u_p1r1_r  (.clock(clock), .en(en), .a(p1), .b(r1), .c(br_pt), .flags(f.p1r1_r));

   // Valid bits travel beside the determinant pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OrientLat; i++) begin
            valid_dly_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_dly_ff[0] <= in_valid;
         for (int i = 1; i < OrientLat; i++) begin
            valid_dly_ff[i] <= valid_dly_ff[i-1];
         end
      end
   end

   // The region code travels beside the determinant pipeline.
   always_ff @(posedge clock) begin
      if (en) begin
         branch_dly_ff[0] <= region.branch;
         for (int i = 1; i < OrientLat; i++) begin
            branch_dly_ff[i] <= branch_dly_ff[i-1];
         end
      end
   end

   assign br = branch_dly_ff[OrientLat-1];

   // Pick the sub-test that belongs to the region and form the result fields.
   always_comb begin
      case (br) inside
         BR_INSIDE:                             sc = SUB_INSIDE;
         BR_VERT_PQR, BR_VERT_RPQ, BR_VERT_QRP: sc = vertex_sub(f);
         default:                               sc = edge_sub(f);
      endcase
      result.overlap = (sc != SUB_NONE);
      result.branch  = br;
      result.subcase = sc;
      result.code    = pack_code(br, sc);
   end

   assign out_valid = valid_dly_ff[OrientLat-1];

endmodule

@@ rtl/triangle_pair_overlap_test.sv @@
// Top level of the triangle pair overlap test: stream ports, input and output registers.
//
// Takes one pair of 2D triangles per beat and reports whether they overlap, which region
// vertex p of the first triangle falls in against the second, the edge or vertex sub-case,
// and the packed code. A new pair is accepted every clock cycle while the result side keeps
// up. Each pair passes through an input register, a three-stage determinant pipeline for
// the region of p1, a region register, a second three-stage determinant pipeline that
// evaluates all sub-test orientations in parallel, and the output register.
// The pipeline advances as a whole; when a result waits untaken, every stage holds and
// req_tready drops in the same cycle.
module triangle_pair_overlap_test (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0 up: a_px, a_py, a_qx, a_qy, a_rx, a_ry,
   // b_px, b_py, b_qx, b_qy, b_rx, b_ry (15 bits each), then zero fill.
   input  logic [tpo_pkg::ReqDataW-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0 up: overlap (1), branch (3), subcase (3), packed_code (19),
   // then zero fill.
   output logic [tpo_pkg::RspDataW-1:0]  rsp_tdata
);
   import tpo_pkg::*;

   logic         en;
   logic         in_valid_ff;
   triangle_type a_in, b_in, a_ff, b_ff;
   logic         region_valid;
   region_type   region;
   logic         sub_valid;
   result_type   result;
   logic         rsp_valid_ff;
   result_type   rsp_ff;

   // The pipeline moves whenever the output register is empty or being drained.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // Unpack the input beat.
   always_comb begin
      a_in.p.x = req_tdata[0*CoordW +: CoordW];
      a_in.p.y = req_tdata[1*CoordW +: CoordW];
      a_in.q.x = req_tdata[2*CoordW +: CoordW];
      a_in.q.y = req_tdata[3*CoordW +: CoordW];
      a_in.r.x = req_tdata[4*CoordW +: CoordW];
      a_in.r.y = req_tdata[5*CoordW +: CoordW];
      b_in.p.x = req_tdata[6*CoordW +: CoordW];
      b_in.p.y = req_tdata[7*CoordW +: CoordW];
      b_in.q.x = req_tdata[8*CoordW +: CoordW];
      b_in.q.y = req_tdata[9*CoordW +: CoordW];
      b_in.r.x = req_tdata[10*CoordW +: CoordW];
      b_in.r.y = req_tdata[11*CoordW +: CoordW];
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   tpo_region u_region (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid_ff),
      .a_trg     (a_ff),
      .b_trg     (b_ff),
      .out_valid (region_valid),
      .region    (region)
   );

   tpo_subtest u_subtest (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (region_valid),
      .region    (region),
      .out_valid (sub_valid),
      .result    (result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sub_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - CodeW - 2*SubW - 1){1'b0}},
                        rsp_ff.code, rsp_ff.subcase, rsp_ff.branch, rsp_ff.overlap};

`ifndef SYNTHESIS
   // The overlap flag agrees with both the sub-case and the packed code.
   a_overlap_subcase : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ff.overlap == (rsp_ff.subcase != SUB_NONE)))
      else $error("overlap flag disagrees with subcase");

   a_overlap_code : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_ff.overlap == (rsp_ff.code != '0)))
      else $error("overlap flag disagrees with packed code");

   // The inside region always reports sub-case one.
   a_inside_sub : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ff.branch == BR_INSIDE) |-> (rsp_ff.subcase == SUB_INSIDE))
      else $error("inside region without subcase one");

   // A held result keeps the whole pipeline frozen, so the input register holds too.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(in_valid_ff) && $stable(region_valid))
      else $error("pipeline moved during a stall");
`endif

endmodule
